[rtl/core/psa_pkg.sv]
// Shared constants, operation codes and size-class helpers for the slab allocator.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package psa_pkg;

  localparam int DEF_PAGE_BYTES   = 4096;
  localparam int DEF_HEADER_BYTES = 40;
  localparam int DEF_NUM_CLASSES  = 32;
  localparam int DEF_MAX_SLOTS    = 512;

  // smallest class holds 8-byte objects
  localparam int MIN_OBJ_SHIFT = 3;

  localparam int SIZE_W   = 32;
  localparam int CLASS_W  = 5;
  localparam int FSLOT_W  = 9;
  localparam int OFFSET_W = 12;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // usable bytes in a page once the header is taken out
  function automatic int page_room(int page_bytes, int header_bytes);
    return (page_bytes > header_bytes) ? (page_bytes - header_bytes) : 0;
  endfunction

  // slots in one page for a class, capped at max_slots
  function automatic int class_slots(int room, int max_slots, int cls);
    int n;
    n = room >> (cls + MIN_OBJ_SHIFT);
    if (n > max_slots) begin
      n = max_slots;
    end
    return n;
  endfunction

  // classes that hold at least one slot; they are always the lowest ones
  function automatic int link_classes(int room, int max_slots, int num_classes);
    int k;
    k = 0;
    for (int c = 0; c < num_classes; c++) begin
      if (class_slots(room, max_slots, c) > 0) begin
        k++;
      end
    end
    return (k > 0) ? k : 1;
  endfunction

endpackage

[rtl/core/psa_front.sv]
// Front end: takes request words, picks the size class and its slot count.
// Depends on psa_pkg; feeds psa_queue.
`timescale 1ns / 1ps

module psa_front #(
  parameter int PAGE_BYTES   = psa_pkg::DEF_PAGE_BYTES,
  parameter int HEADER_BYTES = psa_pkg::DEF_HEADER_BYTES,
  parameter int NUM_CLASSES  = psa_pkg::DEF_NUM_CLASSES,
  parameter int MAX_SLOTS    = psa_pkg::DEF_MAX_SLOTS
) (
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              operation,
  input  logic [psa_pkg::SIZE_W-1:0]        request_size,
  input  logic [psa_pkg::FSLOT_W-1:0]       free_slot,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [psa_pkg::CLASS_W+psa_pkg::FSLOT_W+$clog2(MAX_SLOTS+1):0] q_item
);
  import psa_pkg::*;

  localparam int HW   = $clog2(MAX_SLOTS + 1);
  localparam int ROOM = page_room(PAGE_BYTES, HEADER_BYTES);

  logic [30:0]        above;
  logic [CLASS_W-1:0] cls;
  logic [HW-1:0]      n;

  // class = number of class sizes still below the request, capped at the top class
  always_comb begin
    for (int k = 0; k < 31; k++) begin
      above[k] = (k < NUM_CLASSES - 1) &&
                 ({3'b000, request_size} > (35'd8 << k));
    end
  end

  assign cls = CLASS_W'($countones(above));

  always_comb begin
    n = HW'(class_slots(ROOM, MAX_SLOTS, int'(cls)));
  end

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;
  assign q_item    = {operation, cls, free_slot, n};

endmodule

[rtl/core/psa_queue.sv]
// Short queue of classified request words between front and back end.
// Depends on psa_pkg for its depth.
`timescale 1ns / 1ps

module psa_queue #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);
  import psa_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [W-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/psa_back.sv]
// Back end: per-class slot state, the next-slot link memory and the result register.
// Depends on psa_pkg; drains psa_queue.
`timescale 1ns / 1ps

module psa_back #(
  parameter int PAGE_BYTES   = psa_pkg::DEF_PAGE_BYTES,
  parameter int HEADER_BYTES = psa_pkg::DEF_HEADER_BYTES,
  parameter int NUM_CLASSES  = psa_pkg::DEF_NUM_CLASSES,
  parameter int MAX_SLOTS    = psa_pkg::DEF_MAX_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  logic [psa_pkg::CLASS_W+psa_pkg::FSLOT_W+$clog2(MAX_SLOTS+1):0] q_item,
  output logic                          q_pop,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [psa_pkg::CLASS_W-1:0]   size_class,
  output logic [psa_pkg::FSLOT_W-1:0]   slot_index,
  output logic [psa_pkg::OFFSET_W-1:0]  page_offset,
  output logic                          success
);
  import psa_pkg::*;

  localparam int HW     = $clog2(MAX_SLOTS + 1);
  localparam int SW     = $clog2(MAX_SLOTS);
  localparam int CIW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ITEM_W = 1 + CLASS_W + FSLOT_W + HW;
  localparam int ROOM   = page_room(PAGE_BYTES, HEADER_BYTES);
  localparam int LINK_DEPTH = link_classes(ROOM, MAX_SLOTS, NUM_CLASSES) * MAX_SLOTS;
  localparam int AW     = $clog2(LINK_DEPTH);
  localparam int CMPW   = (HW > FSLOT_W) ? HW : FSLOT_W;
  localparam int EXTW   = (CMPW > OFFSET_W) ? CMPW : OFFSET_W;
  localparam logic [HW-1:0] EMPTY = HW'(MAX_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;

  logic          started [NUM_CLASSES];
  logic [HW-1:0] fresh   [NUM_CLASSES];
  logic [HW-1:0] head    [NUM_CLASSES];

  logic [HW-1:0] link_mem [LINK_DEPTH];
  logic [HW-1:0] rd_data;

  // queue head fields
  op_t                q_op;
  logic [CLASS_W-1:0] q_cls;
  logic [FSLOT_W-1:0] q_fslot;
  logic [HW-1:0]      q_n;
  logic [CIW-1:0]     q_ci;
  logic [HW-1:0]      q_head;
  logic               rd_en;
  logic [AW:0]        rd_addr_full;

  // word being carried out
  op_t                w_op;
  logic [CLASS_W-1:0] w_cls;
  logic [FSLOT_W-1:0] w_fslot;
  logic [HW-1:0]      w_n;

  logic [CIW-1:0]      w_ci;
  logic [HW-1:0]       cur_head;
  logic [HW-1:0]       cur_fresh;
  logic [CMPW-1:0]     fslot_ext;
  logic [CMPW-1:0]     fresh_ext;
  logic [CMPW-1:0]     res_slot;
  logic [EXTW-1:0]     res_ext;
  logic [OFFSET_W-1:0] res_offset;
  logic                ok;
  logic                pop_stack;
  logic                take_fresh;
  logic                do_free;
  logic                fire;
  logic [AW:0]         wr_addr_full;

  assign q_op    = op_t'(q_item[ITEM_W-1]);
  assign q_cls   = q_item[ITEM_W-2 -: CLASS_W];
  assign q_fslot = q_item[HW+FSLOT_W-1 -: FSLOT_W];
  assign q_n     = q_item[HW-1:0];
  assign q_ci    = q_cls[CIW-1:0];
  assign q_head  = head[q_ci];

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign fire  = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);

  // fetch the link under the stack head as the word is popped from the queue, ahead of the stack pop
  assign rd_en = q_pop && (q_op == OP_ALLOC) && (q_n != '0) && (q_head != EMPTY);
  assign rd_addr_full = (AW + 1)'(q_cls) * (AW + 1)'(MAX_SLOTS) +
                        (AW + 1)'(q_head[SW-1:0]);

  always_comb begin
    w_ci       = w_cls[CIW-1:0];
    cur_head   = head[w_ci];
    cur_fresh  = fresh[w_ci];
    fslot_ext  = CMPW'(w_fslot);
    fresh_ext  = CMPW'(cur_fresh);
    ok         = 1'b0;
    pop_stack  = 1'b0;
    take_fresh = 1'b0;
    do_free    = 1'b0;
    res_slot   = '0;
    if (w_op == OP_ALLOC) begin
      if (w_n != '0) begin
        if (cur_head != EMPTY) begin
          pop_stack = 1'b1;
          ok        = 1'b1;
          res_slot  = CMPW'(cur_head);
        end else if (cur_fresh < w_n) begin
          take_fresh = 1'b1;
          ok         = 1'b1;
          res_slot   = CMPW'(cur_fresh);
        end
      end
    end else begin
      res_slot = fslot_ext;
      if (started[w_ci] && (fslot_ext < fresh_ext) && (fslot_ext < CMPW'(MAX_SLOTS))) begin
        do_free = 1'b1;
        ok      = 1'b1;
      end
    end
    res_ext    = EXTW'(res_slot);
    res_offset = ok ? (res_ext[OFFSET_W-1:0] << ({1'b0, w_cls} + 6'(MIN_OBJ_SHIFT))) +
                      OFFSET_W'(HEADER_BYTES)
                    : '0;
    wr_addr_full = (AW + 1)'(w_cls) * (AW + 1)'(MAX_SLOTS) + (AW + 1)'(fslot_ext[SW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= link_mem[rd_addr_full[AW-1:0]];
    end
    if (fire && do_free) begin
      link_mem[wr_addr_full[AW-1:0]] <= cur_head;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_op    <= q_op;
      w_cls   <= q_cls;
      w_fslot <= q_fslot;
      w_n     <= q_n;
    end
    if (fire) begin
      size_class  <= w_cls;
      slot_index  <= res_slot[FSLOT_W-1:0];
      page_offset <= res_offset;
      success     <= ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        started[i] <= 1'b0;
        fresh[i]   <= '0;
        head[i]    <= EMPTY;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (fire) begin
        if ((w_op == OP_ALLOC) && (w_n != '0)) begin
          started[w_ci] <= 1'b1;
        end
        if (pop_stack) begin
          head[w_ci] <= rd_data;
        end
        if (take_fresh) begin
          fresh[w_ci] <= cur_fresh + 1'b1;
        end
        if (do_free) begin
          head[w_ci] <= HW'(w_fslot);
        end
      end
    end
  end

endmodule

[rtl/core/power_of_two_slab_allocator.sv]
// Power-of-two slab allocator: top level joining front end, queue and back end.
// Depends on psa_pkg, psa_front, psa_queue and psa_back.
//
// Each request word allocates or frees one object; its byte size picks the smallest
// power-of-two class of at least 8 bytes, and each class owns one page whose slots are
// handed out fresh in ascending order, while freed slots are reused last in first out.
// Exactly one response word comes back per request, in order. The front end classifies
// a word in its accept cycle and parks it in a two-entry queue; the back end then reads
// the next-slot link memory under the class's stack head as it pops a word from the
// queue, then updates the class state and loads the output register, which waits while
// the response is stalled. It pops no new word until the last one is loaded there. The
// link memory is not cleared after reset: a link is only ever read after a free has
// written it, so the block is ready right after reset.
`timescale 1ns / 1ps

module power_of_two_slab_allocator #(
  parameter int PAGE_BYTES   = psa_pkg::DEF_PAGE_BYTES,
  parameter int HEADER_BYTES = psa_pkg::DEF_HEADER_BYTES,
  parameter int NUM_CLASSES  = psa_pkg::DEF_NUM_CLASSES,
  parameter int MAX_SLOTS    = psa_pkg::DEF_MAX_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          operation,
  input  logic [psa_pkg::SIZE_W-1:0]    request_size,
  input  logic [psa_pkg::FSLOT_W-1:0]   free_slot,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [psa_pkg::CLASS_W-1:0]   size_class,
  output logic [psa_pkg::FSLOT_W-1:0]   slot_index,
  output logic [psa_pkg::OFFSET_W-1:0]  page_offset,
  output logic                          success
);
  import psa_pkg::*;

  localparam int HW     = $clog2(MAX_SLOTS + 1);
  localparam int ITEM_W = 1 + CLASS_W + FSLOT_W + HW;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [ITEM_W-1:0] q_din;
  logic [ITEM_W-1:0] q_dout;

  psa_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_front (
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .request_size(request_size),
    .free_slot   (free_slot),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_din)
  );

  psa_queue #(
    .W(ITEM_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_dout)
  );

  psa_back #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_dout),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .size_class (size_class),
    .slot_index (slot_index),
    .page_offset(page_offset),
    .success    (success)
  );

endmodule
